FILE: rtl/bspe_pkg.sv
`timescale 1ns / 1ps
package bspe_pkg;

  // geometry of the stores and the fixed point formats
  localparam int MAX_POINTS  = 64;
  localparam int MAX_DEGREE  = 7;
  localparam int FRAC_BITS   = 16;
  localparam int KNOT_DEPTH  = MAX_POINTS + MAX_DEGREE + 1;
  localparam int PT_AW       = 6;
  localparam int KNOT_AW     = 7;
  localparam int PT_W        = 96;
  localparam int KNOT_W      = 17;
  localparam logic [16:0] ONE_Q = 17'h10000;

  // divider operand widths
  localparam int DIV_NW = 49;
  localparam int DIV_DW = 19;
  localparam int DIV_CW = 6;

  // request codes
  localparam logic [1:0] REQ_WR_POINT = 2'd0;
  localparam logic [1:0] REQ_WR_KNOT  = 2'd1;
  localparam logic [1:0] REQ_EVAL     = 2'd2;
  localparam logic [1:0] REQ_RSVD     = 2'd3;

  // knot modes
  localparam logic [1:0] KM_CLAMPED   = 2'd0;
  localparam logic [1:0] KM_UNCLAMPED = 2'd1;
  localparam logic [1:0] KM_USER      = 2'd2;
  localparam logic [1:0] KM_RSVD      = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_DEGREE      = 2'd0;
  localparam logic [1:0] CFG_POINT_COUNT = 2'd1;
  localparam logic [1:0] CFG_KNOT_MODE   = 2'd2;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [6:0]         index;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic [16:0]        knot_value;
    logic [16:0]        param;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic               in_range;
    logic [5:0]         span_index;
  } out_item_t;

  typedef struct packed {
    logic [2:0] degree;
    logic [6:0] point_count;
    logic [1:0] knot_mode;
  } cfg_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_KREQ,
    ST_KRAM,
    ST_KDIV,
    ST_SRCH_LO,
    ST_SRCH_HI,
    ST_SRCH_LOOP,
    ST_SRCH_MID,
    ST_BINIT,
    ST_BJ,
    ST_BLEFT,
    ST_BRIGHT,
    ST_BDEN,
    ST_BDIVGO,
    ST_BDIV,
    ST_BMULR,
    ST_BMULL,
    ST_BSAVE,
    ST_SADDR,
    ST_SWAIT,
    ST_SMX,
    ST_SMY,
    ST_SMZ,
    ST_SACC,
    ST_FIN,
    ST_DONE
  } seq_state_t;

  // product / ONE, rounded to nearest, ties away from zero
  function automatic logic signed [47:0] rnd_frac(input logic signed [63:0] x);
    logic [63:0] mag;
    logic [63:0] sh;
    mag = x[63] ? 64'(-x) : 64'(x);
    sh  = (mag + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    return x[63] ? -$signed(sh[47:0]) : $signed(sh[47:0]);
  endfunction

  // saturate to signed 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [55:0] v);
    if (v > 56'sd2147483647) return 32'sh7fffffff;
    if (v < -56'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

FILE: rtl/bspe_ram.sv
`timescale 1ns / 1ps
module bspe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/bspe_div.sv
`timescale 1ns / 1ps
module bspe_div
  import bspe_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic signed [DIV_NW-1:0] num,
  input  logic signed [DIV_DW-1:0] den,
  output logic                     done,
  output logic signed [31:0]       q
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DIV_CW-1:0] cnt_r, cnt_nxt;
  logic [DIV_NW-1:0] a_r, a_nxt;
  logic [DIV_DW-1:0] rem_r, rem_nxt;
  logic [DIV_DW-1:0] dn_r, dn_nxt;
  logic              neg_r, neg_nxt;
  logic signed [31:0] q_r, q_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    a_r   <= a_nxt;
    rem_r <= rem_nxt;
    dn_r  <= dn_nxt;
    neg_r <= neg_nxt;
    q_r   <= q_nxt;
  end

  // restoring division, one quotient bit per cycle, then sign and saturate
  always_comb begin
    logic [DIV_NW-1:0] an;
    logic [DIV_DW-1:0] dn;
    logic [DIV_DW:0]   rem_sh;
    logic              qb;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    a_nxt    = a_r;
    rem_nxt  = rem_r;
    dn_nxt   = dn_r;
    neg_nxt  = neg_r;
    q_nxt    = q_r;
    an       = num[DIV_NW-1] ? DIV_NW'(-num) : DIV_NW'(num);
    dn       = den[DIV_DW-1] ? DIV_DW'(-den) : DIV_DW'(den);
    rem_sh   = {rem_r, a_r[DIV_NW-1]};
    qb       = (rem_sh >= {1'b0, dn_r});
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      a_nxt    = an + DIV_NW'(dn >> 1);
      rem_nxt  = '0;
      dn_nxt   = dn;
      neg_nxt  = num[DIV_NW-1] ^ den[DIV_DW-1];
    end else if (busy_r) begin
      if (cnt_r == DIV_CW'(DIV_NW)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        if (dn_r == '0) begin
          q_nxt = '0;
        end else if (!neg_r) begin
          q_nxt = (a_r > DIV_NW'(32'h7fffffff)) ? 32'sh7fffffff : $signed(a_r[31:0]);
        end else begin
          q_nxt = (a_r > DIV_NW'(33'h80000000)) ? 32'sh80000000 : -$signed(a_r[31:0]);
        end
      end else begin
        cnt_nxt = cnt_r + 1'b1;
        rem_nxt = qb ? DIV_DW'(rem_sh - {1'b0, dn_r}) : rem_sh[DIV_DW-1:0];
        a_nxt   = {a_r[DIV_NW-2:0], qb};
      end
    end
  end

  assign done = done_r;
  assign q    = q_r;

endmodule

FILE: rtl/bspe_core.sv
`timescale 1ns / 1ps
module bspe_core
  import bspe_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [16:0]        param,
  input  cfg_t               cfg,
  output logic               idle,
  output logic               res_valid,
  output out_item_t          res,
  input  logic               res_take,
  output logic [KNOT_AW-1:0] knot_raddr,
  input  logic [KNOT_W-1:0]  knot_rdata,
  output logic [PT_AW-1:0]   pt_raddr,
  input  logic [PT_W-1:0]    pt_rdata
);

  seq_state_t state_r, state_nxt, ret_r, ret_nxt;
  logic [16:0] u_r, u_nxt;
  logic [6:0]  kidx_r, kidx_nxt;
  logic [16:0] knot_r, knot_nxt;
  logic [6:0]  lo_r, lo_nxt, hi_r, hi_nxt;
  logic [5:0]  span_r, span_nxt;
  logic [3:0]  j_r, j_nxt;
  logic [2:0]  r_r, r_nxt;
  logic signed [31:0] n_r [8];
  logic signed [31:0] n_nxt [8];
  logic signed [17:0] left_r [8];
  logic signed [17:0] left_nxt [8];
  logic signed [17:0] right_r [8];
  logic signed [17:0] right_nxt [8];
  logic signed [17:0] tr_r, tr_nxt, tl_r, tl_nxt;
  logic signed [31:0] t_r, t_nxt;
  logic signed [47:0] saved_r, saved_nxt;
  logic signed [63:0] prod_r, prod_nxt;
  logic [PT_W-1:0]    pt_r, pt_nxt;
  logic signed [55:0] accx_r, accx_nxt, accy_r, accy_nxt, accz_r, accz_nxt;
  out_item_t          res_r, res_nxt;

  logic               div_start;
  logic signed [DIV_NW-1:0] div_num;
  logic signed [DIV_DW-1:0] div_den;
  logic               div_done;
  logic signed [31:0] div_q;

  logic [6:0] np, m;
  logic [2:0] p, pd;
  logic [2:0] n_sel;
  logic signed [31:0] n_rd;

  // effective point count, degree and knot count
  always_comb begin
    logic [6:0] lim;
    np  = (cfg.point_count < 7'd2) ? 7'd2 :
          (cfg.point_count > 7'(MAX_POINTS)) ? 7'(MAX_POINTS) : cfg.point_count;
    pd  = (cfg.degree == 3'd0) ? 3'd1 : cfg.degree;
    lim = np - 7'd1;
    p   = ({4'd0, pd} > lim) ? lim[2:0] : pd;
    m   = np + {4'd0, p} + 7'd1;
  end

  bspe_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .q     (div_q)
  );

  assign knot_raddr = kidx_r;
  assign pt_raddr   = PT_AW'(7'({1'b0, span_r}) + 7'(j_r) - 7'(p));
  assign n_sel      = (state_r == ST_SMX || state_r == ST_SMY || state_r == ST_SMZ) ?
                      j_r[2:0] : r_r;
  assign n_rd       = n_r[n_sel];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    ret_r   <= ret_nxt;
    u_r     <= u_nxt;
    kidx_r  <= kidx_nxt;
    knot_r  <= knot_nxt;
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    span_r  <= span_nxt;
    j_r     <= j_nxt;
    r_r     <= r_nxt;
    n_r     <= n_nxt;
    left_r  <= left_nxt;
    right_r <= right_nxt;
    tr_r    <= tr_nxt;
    tl_r    <= tl_nxt;
    t_r     <= t_nxt;
    saved_r <= saved_nxt;
    prod_r  <= prod_nxt;
    pt_r    <= pt_nxt;
    accx_r  <= accx_nxt;
    accy_r  <= accy_nxt;
    accz_r  <= accz_nxt;
    res_r   <= res_nxt;
  end

  // sequencer: knot fetch, span search, basis recurrence, weighted sum
  always_comb begin
    logic signed [31:0] mul_a, mul_b;
    logic               mul_en;
    logic signed [55:0] nsum;
    logic signed [47:0] rp;
    state_nxt = state_r;
    ret_nxt   = ret_r;
    u_nxt     = u_r;
    kidx_nxt  = kidx_r;
    knot_nxt  = knot_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    span_nxt  = span_r;
    j_nxt     = j_r;
    r_nxt     = r_r;
    n_nxt     = n_r;
    left_nxt  = left_r;
    right_nxt = right_r;
    tr_nxt    = tr_r;
    tl_nxt    = tl_r;
    t_nxt     = t_r;
    saved_nxt = saved_r;
    pt_nxt    = pt_r;
    accx_nxt  = accx_r;
    accy_nxt  = accy_r;
    accz_nxt  = accz_r;
    res_nxt   = res_r;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    mul_en    = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    rp        = rnd_frac(prod_r);
    nsum      = 56'(saved_r) + 56'(rp);
    idle      = 1'b0;
    res_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        idle = 1'b1;
        if (start) begin
          u_nxt = param;
          if (param > ONE_Q) begin
            res_nxt   = '0;
            state_nxt = ST_DONE;
          end else begin
            accx_nxt  = '0;
            accy_nxt  = '0;
            accz_nxt  = '0;
            kidx_nxt  = {4'd0, p};
            ret_nxt   = ST_SRCH_LO;
            state_nxt = ST_KREQ;
          end
        end
      end
      // knot fetch: store read or generated value
      ST_KREQ: begin
        case (cfg.knot_mode)
          KM_USER: state_nxt = ST_KRAM;
          KM_UNCLAMPED: begin
            div_start = 1'b1;
            div_num   = $signed({26'd0, kidx_r, 16'd0});
            div_den   = $signed({12'd0, m - 7'd1});
            state_nxt = ST_KDIV;
          end
          default: begin
            if (kidx_r <= {4'd0, p}) begin
              knot_nxt  = '0;
              state_nxt = ret_r;
            end else if (kidx_r < np) begin
              div_start = 1'b1;
              div_num   = $signed({26'd0, kidx_r - {4'd0, p}, 16'd0});
              div_den   = $signed({12'd0, np - {4'd0, p}});
              state_nxt = ST_KDIV;
            end else begin
              knot_nxt  = ONE_Q;
              state_nxt = ret_r;
            end
          end
        endcase
      end
      ST_KRAM: begin
        knot_nxt  = knot_rdata;
        state_nxt = ret_r;
      end
      ST_KDIV: begin
        if (div_done) begin
          knot_nxt  = div_q[16:0];
          state_nxt = ret_r;
        end
      end
      // span search
      ST_SRCH_LO: begin
        if (u_r <= knot_r) begin
          span_nxt  = {3'd0, p};
          state_nxt = ST_BINIT;
        end else begin
          kidx_nxt  = np;
          ret_nxt   = ST_SRCH_HI;
          state_nxt = ST_KREQ;
        end
      end
      ST_SRCH_HI: begin
        if (u_r >= knot_r) begin
          span_nxt  = 6'(np - 7'd1);
          state_nxt = ST_BINIT;
        end else begin
          lo_nxt    = {4'd0, p};
          hi_nxt    = np;
          state_nxt = ST_SRCH_LOOP;
        end
      end
      ST_SRCH_LOOP: begin
        if ((hi_r - lo_r) > 7'd1) begin
          kidx_nxt  = 7'((8'(lo_r) + 8'(hi_r)) >> 1);
          ret_nxt   = ST_SRCH_MID;
          state_nxt = ST_KREQ;
        end else begin
          span_nxt  = lo_r[5:0];
          state_nxt = ST_BINIT;
        end
      end
      ST_SRCH_MID: begin
        if (u_r < knot_r) begin
          hi_nxt = kidx_r;
        end else begin
          lo_nxt = kidx_r;
        end
        state_nxt = ST_SRCH_LOOP;
      end
      // basis recurrence
      ST_BINIT: begin
        n_nxt[0]     = $signed({15'd0, ONE_Q});
        left_nxt[0]  = '0;
        right_nxt[0] = '0;
        j_nxt        = 4'd1;
        state_nxt    = ST_BJ;
      end
      ST_BJ: begin
        kidx_nxt  = 7'({1'b0, span_r}) + 7'd1 - 7'(j_r);
        ret_nxt   = ST_BLEFT;
        state_nxt = ST_KREQ;
      end
      ST_BLEFT: begin
        left_nxt[j_r[2:0]] = $signed({1'b0, u_r}) - $signed({1'b0, knot_r});
        kidx_nxt  = 7'({1'b0, span_r}) + 7'(j_r);
        ret_nxt   = ST_BRIGHT;
        state_nxt = ST_KREQ;
      end
      ST_BRIGHT: begin
        right_nxt[j_r[2:0]] = $signed({1'b0, knot_r}) - $signed({1'b0, u_r});
        saved_nxt = '0;
        r_nxt     = '0;
        state_nxt = ST_BDEN;
      end
      ST_BDEN: begin
        tr_nxt    = right_r[r_r + 3'd1];
        tl_nxt    = left_r[j_r[2:0] - r_r];
        state_nxt = ST_BDIVGO;
      end
      ST_BDIVGO: begin
        div_start = 1'b1;
        div_num   = $signed({n_rd[31], n_rd, 16'd0});
        div_den   = 19'(tr_r) + 19'(tl_r);
        state_nxt = ST_BDIV;
      end
      ST_BDIV: begin
        if (div_done) begin
          t_nxt     = div_q;
          state_nxt = ST_BMULR;
        end
      end
      ST_BMULR: begin
        mul_en    = 1'b1;
        mul_a     = 32'(tr_r);
        mul_b     = t_r;
        state_nxt = ST_BMULL;
      end
      ST_BMULL: begin
        n_nxt[r_r] = sat32(nsum);
        mul_en     = 1'b1;
        mul_a      = 32'(tl_r);
        mul_b      = t_r;
        state_nxt  = ST_BSAVE;
      end
      ST_BSAVE: begin
        saved_nxt = rp;
        if ((4'(r_r) + 4'd1) < j_r) begin
          r_nxt     = r_r + 3'd1;
          state_nxt = ST_BDEN;
        end else begin
          n_nxt[j_r[2:0]] = sat32(56'(rp));
          if (j_r < {1'b0, p}) begin
            j_nxt     = j_r + 4'd1;
            state_nxt = ST_BJ;
          end else begin
            j_nxt     = '0;
            state_nxt = ST_SADDR;
          end
        end
      end
      // weighted sum of control points
      ST_SADDR: state_nxt = ST_SWAIT;
      ST_SWAIT: begin
        pt_nxt    = pt_rdata;
        state_nxt = ST_SMX;
      end
      ST_SMX: begin
        mul_en    = 1'b1;
        mul_a     = n_rd;
        mul_b     = $signed(pt_r[95:64]);
        state_nxt = ST_SMY;
      end
      ST_SMY: begin
        accx_nxt  = accx_r + 56'(rp);
        mul_en    = 1'b1;
        mul_a     = n_rd;
        mul_b     = $signed(pt_r[63:32]);
        state_nxt = ST_SMZ;
      end
      ST_SMZ: begin
        accy_nxt  = accy_r + 56'(rp);
        mul_en    = 1'b1;
        mul_a     = n_rd;
        mul_b     = $signed(pt_r[31:0]);
        state_nxt = ST_SACC;
      end
      ST_SACC: begin
        accz_nxt = accz_r + 56'(rp);
        if (j_r < {1'b0, p}) begin
          j_nxt     = j_r + 4'd1;
          state_nxt = ST_SADDR;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        res_nxt.point_x    = sat32(accx_r);
        res_nxt.point_y    = sat32(accy_r);
        res_nxt.point_z    = sat32(accz_r);
        res_nxt.in_range   = 1'b1;
        res_nxt.span_index = span_r;
        state_nxt          = ST_DONE;
      end
      ST_DONE: begin
        res_valid = 1'b1;
        if (res_take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    prod_nxt = mul_en ? mul_a * mul_b : prod_r;
  end

  assign res = res_r;

endmodule

FILE: rtl/bspline_point_evaluator_top.sv
`timescale 1ns / 1ps
// B-spline point evaluator. Input beats on in_*: write a control point,
// write a knot, or evaluate at a Q1.16 parameter; only an evaluation gives
// a result beat on out_*. Configuration (degree, point count, knot mode)
// is written on cfg_*, by the user only while the block is idle; the
// block itself does not enforce this, and cfg_ready is always high.
// A parameter above one gives a zero point. An evaluation of degree p runs
// on one bit-serial divider and one 32x32 multiplier: up to log2(n)+2
// knot fetches for the span plus 2p more for the recurrence, p(p+1)/2
// quotients, and three products per control point in the sum.
// in_ready is low while an evaluation is in progress. The result is held
// in an output register, so the next beat is taken while it waits; a
// finished evaluation waits for that register if the receiver stalls.
// Reset (synchronous, active low) clears control state and sets degree 3,
// point count 4, clamped knots; the point and knot stores are not cleared.
module bspline_point_evaluator_top
  import bspe_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [6:0] cfg_data
);

  cfg_t      cfg_r, cfg_nxt;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  logic               in_acc;
  logic               core_idle, res_valid, res_take;
  out_item_t          res;
  logic               pt_we, knot_we;
  logic [PT_AW-1:0]   pt_raddr;
  logic [PT_W-1:0]    pt_rdata;
  logic [KNOT_AW-1:0] knot_raddr;
  logic [KNOT_W-1:0]  knot_rdata;

  assign cfg_ready = 1'b1;
  assign in_ready  = core_idle;
  assign in_acc    = in_valid && in_ready;
  assign pt_we     = in_acc && (in_data.req_type == REQ_WR_POINT) &&
                     (in_data.index < 7'(MAX_POINTS));
  assign knot_we   = in_acc && (in_data.req_type == REQ_WR_KNOT) &&
                     (in_data.index < 7'(KNOT_DEPTH));
  assign res_take  = res_valid && (!out_valid_r || out_ready);

  // control point and knot stores
  bspe_ram #(.WIDTH(PT_W), .DEPTH(MAX_POINTS)) u_pt_ram (
    .clk   (clk),
    .we    (pt_we),
    .waddr (in_data.index[PT_AW-1:0]),
    .wdata ({in_data.coord_x, in_data.coord_y, in_data.coord_z}),
    .raddr (pt_raddr),
    .rdata (pt_rdata)
  );

  bspe_ram #(.WIDTH(KNOT_W), .DEPTH(KNOT_DEPTH)) u_knot_ram (
    .clk   (clk),
    .we    (knot_we),
    .waddr (in_data.index),
    .wdata (in_data.knot_value),
    .raddr (knot_raddr),
    .rdata (knot_rdata)
  );

  bspe_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (in_acc && (in_data.req_type == REQ_EVAL)),
    .param      (in_data.param),
    .cfg        (cfg_r),
    .idle       (core_idle),
    .res_valid  (res_valid),
    .res        (res),
    .res_take   (res_take),
    .knot_raddr (knot_raddr),
    .knot_rdata (knot_rdata),
    .pt_raddr   (pt_raddr),
    .pt_rdata   (pt_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= '{degree: 3'd3, point_count: 7'd4, knot_mode: KM_CLAMPED};
      out_valid_r <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  // configuration writes and result register
  always_comb begin
    cfg_nxt       = cfg_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DEGREE:      cfg_nxt.degree      = cfg_data[2:0];
        CFG_POINT_COUNT: cfg_nxt.point_count = cfg_data;
        CFG_KNOT_MODE:   cfg_nxt.knot_mode   = cfg_data[1:0];
        default:         cfg_nxt             = cfg_r;
      endcase
    end
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (res_take) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // an evaluation beat holds off the next input
  a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.req_type == REQ_EVAL) |=> !in_ready)
    else $error("input taken during evaluation");

  // an out-of-range result carries a zero point
  a_zero_point: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.in_range) |->
      (out_data.point_x == 0 && out_data.point_y == 0 &&
       out_data.point_z == 0 && out_data.span_index == 0))
    else $error("nonzero point outside range");

  // store writes never produce a result
  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.req_type != REQ_EVAL && !out_valid) |=> !out_valid)
    else $error("result from a write beat");

endmodule
